// ----- hdl/smlc_pkg.sv -----
// Shared types, constants and helpers of the stereo mixer with low-pass and clip.
// No dependencies; every other file of the block but smlc_if imports this package.
package smlc_pkg;

  localparam int unsigned PCT_DIV     = 100;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned OP_W        = 32;
  localparam int unsigned PROD_W      = 2 * OP_W;
  localparam int unsigned SAMPLE_W    = 16;
  // Magnitude of any value that is divided by 100 stays below 2**DIV_W.
  localparam int unsigned DIV_W       = 27;
  localparam int unsigned PCT_LOG2    = 7;
  localparam int unsigned RECIP_SHIFT = DIV_W + PCT_LOG2;
  localparam int unsigned QUOT_W      = RECIP_SHIFT + OP_W - RECIP_SHIFT - 11;
  localparam int unsigned MIX_W       = QUOT_W + 1;
  localparam int unsigned FA_W        = 17;

  // Rounded-up reciprocal of 100: exact floor division for dividends below 2**DIV_W.
  localparam logic [OP_W-1:0] RECIP_PCT =
      OP_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));
  localparam logic [OP_W-1:0] UNITY_Q16 = OP_W'(64'd1 << FRAC_BITS);

  localparam logic signed [SAMPLE_W-1:0] CLIP_HI = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] CLIP_LO = 16'sh8000;

  typedef enum logic [7:0] {
    REG_PSG_GAIN       = 8'd0,
    REG_FM_GAIN        = 8'd1,
    REG_LOWPASS_ENABLE = 8'd2,
    REG_LOWPASS_RANGE  = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] psg_gain;
    logic [7:0] fm_gain;
    logic       lp_en;
    logic [6:0] pole_pct;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] psg_sample;
    logic signed [19:0] fm_left;
    logic signed [19:0] fm_right;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
  } mul_req_t;

  // Saturate a mixed channel value to the signed 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [MIX_W-1:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > MIX_W'(CLIP_HI)) begin
      res = CLIP_HI;
    end else if (v < MIX_W'(CLIP_LO)) begin
      res = CLIP_LO;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/smlc_if.sv -----
// Valid/ready channel interfaces: sample input, mixed result output, register writes.
// Widths follow the field widths held in smlc_pkg.
interface smlc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] psg_sample;
  logic signed [19:0] fm_left;
  logic signed [19:0] fm_right;
  modport source (output valid, psg_sample, fm_left, fm_right, input ready);
  modport sink   (input valid, psg_sample, fm_left, fm_right, output ready);
endinterface

interface smlc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface smlc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/smlc_mul.sv -----
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// Depends on smlc_pkg for the operand request type.
module smlc_mul import smlc_pkg::*; (
  input  logic              clk_i,
  input  mul_req_t          req_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(req_i.op_a) * PROD_W'(req_i.op_b);

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule

// ----- hdl/smlc_core.sv -----
// Sequencer and datapath: gains, divide by 100, one-pole filter, clip.
// Depends on smlc_pkg and drives the shared multiplier smlc_mul.
module smlc_core import smlc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0_0000_0000_0001,
    ST_MPSG = 13'b0_0000_0000_0010,
    ST_DPSG = 13'b0_0000_0000_0100,
    ST_MFL  = 13'b0_0000_0000_1000,
    ST_DFL  = 13'b0_0000_0001_0000,
    ST_MFR  = 13'b0_0000_0010_0000,
    ST_DFR  = 13'b0_0000_0100_0000,
    ST_MFA  = 13'b0_0000_1000_0000,
    ST_MPL  = 13'b0_0001_0000_0000,
    ST_MQL  = 13'b0_0010_0000_0000,
    ST_MPR  = 13'b0_0100_0000_0000,
    ST_MQR  = 13'b0_1000_0000_0000,
    ST_DONE = 13'b1_0000_0000_0000
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q;
  logic              sign_q;
  logic [MIX_W-1:0]  psg_mix_q, left_q, right_q;
  logic [FA_W-1:0]   fa_q;
  logic [OP_W-1:0]   part_q;
  logic [OP_W-1:0]   lacc_q, racc_q;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;
  logic [OP_W-1:0]   prod_lo, prod_neg;
  logic [DIV_W-1:0]  mag;
  logic [MIX_W-1:0]  quot_ext, quot_s;
  logic [FA_W-1:0]   fa_new;
  logic [OP_W-1:0]   fb, acc_sum;

  smlc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign prod_lo  = prod[OP_W-1:0];
  assign prod_neg = OP_W'(0) - prod_lo;
  assign mag      = prod_lo[OP_W-1] ? prod_neg[DIV_W-1:0] : prod_lo[DIV_W-1:0];
  assign quot_ext = MIX_W'(prod[RECIP_SHIFT +: QUOT_W]);
  assign quot_s   = sign_q ? (MIX_W'(0) - quot_ext) : quot_ext;
  assign fa_new   = prod[RECIP_SHIFT +: FA_W];
  assign fb       = UNITY_Q16 - OP_W'(fa_q);
  assign acc_sum  = part_q + prod_lo;

  always_comb begin
    state_d      = state_q;
    mul_req      = '0;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MPSG;
        end
      end
      ST_MPSG: begin
        mul_req.op_a = OP_W'(item_q.psg_sample);
        mul_req.op_b = OP_W'(cfg_i.psg_gain);
        state_d      = ST_DPSG;
      end
      ST_DPSG: begin
        mul_req.op_a = OP_W'(mag);
        mul_req.op_b = RECIP_PCT;
        state_d      = ST_MFL;
      end
      ST_MFL: begin
        mul_req.op_a = OP_W'(item_q.fm_left);
        mul_req.op_b = OP_W'(cfg_i.fm_gain);
        state_d      = ST_DFL;
      end
      ST_DFL: begin
        mul_req.op_a = OP_W'(mag);
        mul_req.op_b = RECIP_PCT;
        state_d      = ST_MFR;
      end
      ST_MFR: begin
        mul_req.op_a = OP_W'(item_q.fm_right);
        mul_req.op_b = OP_W'(cfg_i.fm_gain);
        state_d      = ST_DFR;
      end
      ST_DFR: begin
        mul_req.op_a = OP_W'(mag);
        mul_req.op_b = RECIP_PCT;
        state_d      = ST_MFA;
      end
      ST_MFA: begin
        // The filter factor is the range scaled to 16.16 and divided by 100.
        mul_req.op_a = OP_W'(cfg_i.pole_pct) << FRAC_BITS;
        mul_req.op_b = RECIP_PCT;
        state_d      = cfg_i.lp_en ? ST_MPL : ST_DONE;
      end
      ST_MPL: begin
        mul_req.op_a = OP_W'($signed(lacc_q[OP_W-1:FRAC_BITS]));
        mul_req.op_b = OP_W'(fa_new);
        state_d      = ST_MQL;
      end
      ST_MQL: begin
        mul_req.op_a = OP_W'($signed(left_q));
        mul_req.op_b = fb;
        state_d      = ST_MPR;
      end
      ST_MPR: begin
        mul_req.op_a = OP_W'($signed(racc_q[OP_W-1:FRAC_BITS]));
        mul_req.op_b = OP_W'(fa_q);
        state_d      = ST_MQR;
      end
      ST_MQR: begin
        mul_req.op_a = OP_W'($signed(right_q));
        mul_req.op_b = fb;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // With the filter on, the last product is requested again so that it stays
        // in place while the result waits for the output register.
        mul_req.op_a = OP_W'($signed(right_q));
        mul_req.op_b = fb;
        res_valid_o  = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The right accumulator is complete only after the last product lands in DONE.
  always_comb begin
    if (cfg_i.lp_en) begin
      res_o.left_out  = lacc_q[OP_W-1:FRAC_BITS];
      res_o.right_out = acc_sum[OP_W-1:FRAC_BITS];
    end else begin
      res_o.left_out  = clip16(left_q);
      res_o.right_out = clip16(right_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lacc_q  <= '0;
      racc_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MPR) begin
        lacc_q <= acc_sum;
      end
      if (state_q == ST_DONE && res_ready_i && cfg_i.lp_en) begin
        racc_q <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_q <= item_i;
        end
      end
      ST_DPSG, ST_DFL, ST_DFR: begin
        sign_q <= prod_lo[OP_W-1];
      end
      ST_MFL: begin
        psg_mix_q <= quot_s;
      end
      ST_MFR: begin
        left_q <= psg_mix_q + quot_s;
      end
      ST_MFA: begin
        right_q <= psg_mix_q + quot_s;
      end
      ST_MPL: begin
        fa_q <= fa_new;
      end
      ST_MQL, ST_MQR: begin
        part_q <= prod_lo;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/stereo_mixer_lowpass_clip_unit.sv -----
// Top level of the stereo mixer with one-pole low-pass and, when bypassed, 16-bit clipping.
// Depends on smlc_pkg, the channel interfaces in smlc_if and the core smlc_core.
//
//   channel   modport  payload                              role
//   in_i      sink     psg_sample, fm_left, fm_right        one sample set per item
//   out_o     source   left_out, right_out                  one mixed pair per item
//   cfg_i     sink     index, data                          register writes, always ready
//
// An item steps through its gain products, divides and filter factor, then four filter
// products if the filter is enabled; every product and every divide by 100 goes
// through one shared 32 x 32 multiplier, one use per cycle.
// Reset restores the register defaults and clears both filter accumulators.
// A finished pair waits in the output register, so a new item is taken while the
// previous result is still unread; the core holds in its final step only if the
// output register is still full when the next pair is ready.
module stereo_mixer_lowpass_clip_unit import smlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  smlc_in_if.sink    in_i,
  smlc_out_if.source out_o,
  smlc_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  item_t   item;
  result_t res, out_q;
  logic    out_valid_q;
  logic    core_ready, res_valid, res_ready;

  // Register writes. Unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.psg_gain <= 8'd100;
      cfg_q.fm_gain  <= 8'd100;
      cfg_q.lp_en    <= 1'b0;
      cfg_q.pole_pct <= 7'd50;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_PSG_GAIN:       cfg_q.psg_gain <= cfg_i.data;
        REG_FM_GAIN:        cfg_q.fm_gain  <= cfg_i.data;
        REG_LOWPASS_ENABLE: cfg_q.lp_en    <= cfg_i.data[0];
        REG_LOWPASS_RANGE:  cfg_q.pole_pct <= cfg_i.data[6:0];
        default: begin
        end
      endcase
    end
  end

  assign item.psg_sample = in_i.psg_sample;
  assign item.fm_left    = in_i.fm_left;
  assign item.fm_right   = in_i.fm_right;
  assign in_i.ready      = core_ready;

  smlc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (core_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: refilled in the same cycle that its pair is taken.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_q.left_out;
  assign out_o.right_out = out_q.right_out;

  // After an accepted item the core is neither ready for input nor offering a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_i.valid && in_i.ready) |=> (!core_ready && !res_valid))
    else $error("core took an item and was not busy with it");

  // A result handed to the output register returns the core to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid && res_ready) |=> (core_ready && out_valid_q))
    else $error("result handoff did not free the core or fill the output");

  // The core never offers a result while it is also taking an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid |-> !core_ready)
    else $error("core offered a result while ready for input");

  // The output register fills only from a core handoff.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(res_valid && res_ready))
    else $error("output became valid without a result from the core");

endmodule

// ----- test/tb_mix_sb_pkg.sv -----
// Scoreboard for the stereo mixer testbench. It predicts each mixed pair and checks the results.
// Depends on smlc_pkg for the item and result types and the register indexes.
package tb_mix_sb_pkg;
  import smlc_pkg::*;

  class stereo_pair_checker;
    localparam longint PERCENT = 100;

    // Register copy, reset values first.
    logic [7:0]  psg_gain  = 8'd100;
    logic [7:0]  fm_gain   = 8'd100;
    logic        lp_en     = 1'b0;
    logic [6:0]  pole_pct  = 7'd50;
    logic [31:0] left_acc  = '0;
    logic [31:0] right_acc = '0;

    result_t     expected_pairs[$];
    int unsigned errors    = 0;
    int unsigned pairs_seen = 0;

    function void write_reg(logic [7:0] idx, logic [7:0] data);
      case (idx)
        REG_PSG_GAIN:       psg_gain = data;
        REG_FM_GAIN:        fm_gain  = data;
        REG_LOWPASS_ENABLE: lp_en    = data[0];
        REG_LOWPASS_RANGE:  pole_pct = data[6:0];
        default: ;
      endcase
    endfunction

    // One pole step in 16.16; both products and the sum wrap at 32 bits.
    function logic [31:0] next_accum(logic [31:0] acc, longint x, logic [31:0] fa,
                                     logic [31:0] fb);
      logic [31:0] held;
      logic [31:0] xw;
      held = {{16{acc[31]}}, acc[31:16]};
      xw   = 32'(x);
      return held * fa + xw * fb;
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    function void note_sample(item_t s);
      longint      tone;
      longint      left;
      longint      right;
      logic [31:0] fa;
      logic [31:0] fb;
      result_t     want;
      tone  = (longint'($signed(s.psg_sample)) * longint'(psg_gain)) / PERCENT;
      left  = tone + (longint'($signed(s.fm_left)) * longint'(fm_gain)) / PERCENT;
      right = tone + (longint'($signed(s.fm_right)) * longint'(fm_gain)) / PERCENT;
      if (lp_en) begin
        fa        = (32'(pole_pct) << 16) / 32'd100;
        fb        = 32'h0001_0000 - fa;
        left_acc  = next_accum(left_acc, left, fa, fb);
        right_acc = next_accum(right_acc, right, fa, fb);
        left      = longint'($signed(left_acc[31:16]));
        right     = longint'($signed(right_acc[31:16]));
      end
      want.left_out  = sat16(left);
      want.right_out = sat16(right);
      expected_pairs.push_back(want);
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_pair(result_t got);
      result_t want;
      pairs_seen++;
      if (expected_pairs.size() == 0) begin
        report($sformatf("pair %0d arrived with none expected: L=%0d R=%0d", pairs_seen,
                         got.left_out, got.right_out));
      end else begin
        want = expected_pairs.pop_front();
        if (got.left_out !== want.left_out)
          report($sformatf("pair %0d left_out got %0d want %0d", pairs_seen, got.left_out,
                           want.left_out));
        if (got.right_out !== want.right_out)
          report($sformatf("pair %0d right_out got %0d want %0d", pairs_seen,
                           got.right_out, want.right_out));
      end
    endtask
  endclass

endpackage

// ----- test/tb_top.sv -----
// Testbench for stereo_mixer_lowpass_clip_unit: directed and random sample sets under
// several gain and filter settings, checked pair by pair against tb_mix_sb_pkg.
// Depends on smlc_pkg, the channel interfaces of smlc_if and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smlc_pkg::*;
  import tb_mix_sb_pkg::*;

  // The watchdog gives up after this many cycles without any handshake.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 53;

  // Output stall patterns; the receiver draws one at random for each stretch of random length.
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_BURSTY, RX_THIRD} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smlc_in_if  in_if();
  smlc_out_if out_if();
  smlc_cfg_if cfg_if();

  stereo_pair_checker mix_model = new();

  stereo_mixer_lowpass_clip_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Items go out in bursts; when a burst is used up, valid drops for a
  // random gap and a new burst length is drawn. Long bursts give stretches where the
  // sender never idles, short gaps land on every step of the unit's sequence.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_sample(input item_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.psg_sample <= s.psg_sample;
    in_if.fm_left    <= s.fm_left;
    in_if.fm_right   <= s.fm_right;
    do @(posedge clk_i); while (!in_if.ready);
    mix_model.note_sample(s);
    @(negedge clk_i);
  endtask

  // Drop valid and wait at a falling edge until every predicted pair has been read.
  task automatic drain_pairs();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (mix_model.pending() != 0);
  endtask

  function automatic item_t sample_of(int psg, int fl, int fr);
    item_t s;
    s.psg_sample = 16'(psg);
    s.fm_left    = 20'(fl);
    s.fm_right   = 20'(fr);
    return s;
  endfunction

  // Mostly full-range random samples, with some small values (where the truncation
  // of the divide by 100 shows) and some rail values (where clipping and wrap show).
  function automatic item_t random_sample();
    item_t s;
    case ($urandom_range(0, 9))
      0: begin
        s.psg_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        s.fm_left    = $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
        s.fm_right   = $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
      end
      1, 2: begin
        s.psg_sample = 16'(int'($urandom_range(0, 400)) - 200);
        s.fm_left    = 20'(int'($urandom_range(0, 400)) - 200);
        s.fm_right   = 20'(int'($urandom_range(0, 400)) - 200);
      end
      default: begin
        s.psg_sample = 16'($urandom);
        s.fm_left    = 20'($urandom);
        s.fm_right   = 20'($urandom);
      end
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes. These are only issued with the unit idle: the caller drains all
  // pairs first. Valid stays high across the writes of one group and drops at the end.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    mix_model.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // With junk set, the one-bit and seven-bit registers also get their unused upper
  // bits set at random, and a write to an unassigned index is thrown in, which the
  // unit must ignore.
  task automatic apply_settings(input logic [7:0] pg, input logic [7:0] fg, input logic en,
                                input logic [6:0] rng, input bit junk);
    logic [7:0] en_data;
    logic [7:0] rng_data;
    en_data  = junk ? {7'($urandom), en} : {7'd0, en};
    rng_data = junk ? {1'($urandom), rng} : {1'b0, rng};
    write_reg(REG_PSG_GAIN, pg);
    if (junk) write_reg(8'($urandom_range(REG_LOWPASS_RANGE + 1, 255)), 8'($urandom));
    write_reg(REG_FM_GAIN, fg);
    write_reg(REG_LOWPASS_RANGE, rng_data);
    write_reg(REG_LOWPASS_ENABLE, en_data);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd100;
      2: return 8'd200;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [6:0] pick_range();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      3: return 7'd1;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: ready changes at the falling edge following one of several
  // patterns, including long stalls and stretches with ready held high.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned run_left  = 0;
  logic        run_level = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 160);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: out_if.ready <= 1'b1;
        RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
        RX_BURSTY: begin
          if (run_left == 0) begin
            run_level = !run_level;
            run_left  = run_level ? $urandom_range(1, 6) : $urandom_range(1, 24);
          end
          run_left--;
          out_if.ready <= run_level;
        end
        default: out_if.ready <= (mode_left % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking and the watchdog. Outputs are sampled at the rising edge, before
  // the unit's own updates of that edge take effect.
  // ---------------------------------------------------------------------------
  result_t     seen_pair;
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen_pair.left_out  = out_if.left_out;
        seen_pair.right_out = out_if.right_out;
        mix_model.check_pair(seen_pair);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles, %0d pairs still expected",
                 STALL_LIMIT, mix_model.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid      = 1'b0;
    in_if.psg_sample = '0;
    in_if.fm_left    = '0;
    in_if.fm_right   = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: unity gains, filter bypassed. Rails must clip both ways.
    send_sample(sample_of(0, 0, 0));
    send_sample(sample_of(32767, 524287, 524287));
    send_sample(sample_of(-32768, -524288, -524288));
    send_sample(sample_of(-1, -1, 1));
    send_sample(sample_of(32767, -524288, 524287));
    drain_pairs();

    // Largest tone gain with FM muted; small negatives show truncation toward zero.
    apply_settings(8'd255, 8'd0, 1'b0, 7'd50, 1'b0);
    send_sample(sample_of(32767, 524287, -524288));
    send_sample(sample_of(-32768, 1, 1));
    send_sample(sample_of(-3, 5, 5));
    drain_pairs();

    // Odd gains, FM gain above the nominal maximum of 200.
    apply_settings(8'd37, 8'd201, 1'b0, 7'd50, 1'b0);
    send_sample(sample_of(-3, -7, 7));
    send_sample(sample_of(1, -1, -1));
    drain_pairs();

    // Filter on at range 0: the pole vanishes and the 16-bit slice of the
    // accumulator wraps large sums instead of clipping them.
    apply_settings(8'd100, 8'd100, 1'b1, 7'd0, 1'b0);
    send_sample(sample_of(32767, 524287, -524288));
    send_sample(sample_of(-5, 3, 9));
    drain_pairs();

    // Range 100: the input weight is zero and the accumulator simply holds.
    apply_settings(8'd100, 8'd100, 1'b1, 7'd100, 1'b0);
    send_sample(sample_of(1000, 2000, -3000));
    send_sample(sample_of(-32768, 524287, -524288));
    drain_pairs();

    // Range above 100 makes the input weight negative modulo 2**32.
    apply_settings(8'd255, 8'd255, 1'b1, 7'd127, 1'b0);
    send_sample(sample_of(32767, 524287, 524287));
    send_sample(sample_of(-32768, -524288, -524288));
    send_sample(sample_of(12345, -54321, 54321));
    drain_pairs();

    // Bypass must leave the accumulators alone; re-enabling picks them up again.
    apply_settings(8'd100, 8'd100, 1'b0, 7'd127, 1'b1);
    send_sample(sample_of(100, 100, 100));
    drain_pairs();
    apply_settings(8'd100, 8'd100, 1'b1, 7'd50, 1'b1);
    send_sample(sample_of(100, 100, 100));
    drain_pairs();

    // Random phases, mostly with the filter running since that is where state lives.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_settings(pick_gain(), pick_gain(), $urandom_range(0, 3) != 0, pick_range(),
                     $urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(random_sample());
        // Now and then the sender holds off until the unit is completely empty.
        if ($urandom_range(0, 29) == 0) drain_pairs();
      end
      drain_pairs();
    end

    // Let any stray pair surface before deciding.
    repeat (30) @(negedge clk_i);
    if (mix_model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
